### src/itw_pkg.sv
// itw_pkg: shared widths, word codes and controller/datapath interface types
// for the integer to word tokens unit. No dependencies.
`timescale 1ns / 1ps

package itw_pkg;

  localparam int NUM_W    = 31;          // input number width
  localparam int WORD_W   = 5;           // word code width
  localparam int DIGITS   = 10;          // decimal digits for 2^31-1
  localparam int BCD_W    = 4 * DIGITS;
  localparam int GROUPS   = 4;           // units, thousands, millions, billions
  localparam int GRP_W    = 2;
  localparam int SHIFT_W  = 5;           // counts NUM_W conversion steps

  // word codes
  localparam logic [WORD_W-1:0] WORD_ZERO       = 5'd0;
  localparam logic [WORD_W-1:0] WORD_TEN        = 5'd10;
  localparam logic [WORD_W-1:0] WORD_TENS_BASE  = 5'd18;  // 18 + tens digit
  localparam logic [WORD_W-1:0] WORD_HUNDRED    = 5'd28;  // scale = 28 + group

  // one word position inside a group
  typedef enum logic [2:0] {
    SLOT_HDIGIT,
    SLOT_HUNDRED,
    SLOT_TENS,
    SLOT_UNIT,
    SLOT_SCALE
  } slot_t;

  // commands from controller to datapath
  typedef struct packed {
    logic             load;
    logic             shift;
    logic             emit;
    logic             flush;
    logic             zero;
    logic [GRP_W-1:0] grp;
    slot_t            slot;
  } itw_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_zero;
  } itw_stat_t;

endpackage

### src/itw_datapath.sv
// itw_datapath: double-dabble binary to BCD converter, group word decoder
// and one-word look-ahead output stage. Depends on itw_pkg.
`timescale 1ns / 1ps

module itw_datapath
  import itw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [NUM_W-1:0]  number,
  input  itw_cmd_t          cmd,
  output itw_stat_t         stat,
  output logic              word_valid,
  output logic [WORD_W-1:0] word_code,
  output logic              last_word
);

  logic [NUM_W-1:0]  bin;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_adj;
  logic [WORD_W-1:0] pending;
  logic              pending_valid;

  logic [BCD_W+7:0]  bcd_ext;
  logic [11:0]       grp_digits;
  logic [3:0]        dig_h;
  logic [3:0]        dig_t;
  logic [3:0]        dig_u;
  logic              grp_nonzero;
  logic              hit;
  logic [WORD_W-1:0] word;

  // add three to every digit of five or more before each shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign stat.is_zero = (bcd == '0);

  // digits of the selected group, billions padded with zeros
  assign bcd_ext    = {8'd0, bcd};
  assign grp_digits = bcd_ext[12*cmd.grp +: 12];
  assign dig_h      = grp_digits[11:8];
  assign dig_t      = grp_digits[7:4];
  assign dig_u      = grp_digits[3:0];
  assign grp_nonzero = (grp_digits != '0);

  // word for the current slot, hit when the slot yields a word
  always_comb begin
    hit  = 1'b0;
    word = WORD_ZERO;
    case (cmd.slot)
      SLOT_HDIGIT: begin
        hit  = (dig_h != 4'd0);
        word = {1'b0, dig_h};
      end
      SLOT_HUNDRED: begin
        hit  = (dig_h != 4'd0);
        word = WORD_HUNDRED;
      end
      SLOT_TENS: begin
        if (dig_t >= 4'd2) begin
          hit  = 1'b1;
          word = WORD_TENS_BASE + {1'b0, dig_t};
        end else if (dig_t == 4'd1) begin
          hit  = 1'b1;
          word = WORD_TEN + {1'b0, dig_u};
        end else begin
          hit  = (dig_u != 4'd0);
          word = {1'b0, dig_u};
        end
      end
      SLOT_UNIT: begin
        hit  = (dig_t >= 4'd2) && (dig_u != 4'd0);
        word = {1'b0, dig_u};
      end
      SLOT_SCALE: begin
        hit  = grp_nonzero && (cmd.grp != '0);
        word = WORD_HUNDRED + {{(WORD_W-GRP_W){1'b0}}, cmd.grp};
      end
      default: begin
        hit  = 1'b0;
        word = WORD_ZERO;
      end
    endcase
  end

  // conversion registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= number;
      bcd <= '0;
    end else if (cmd.shift) begin
      {bcd, bin} <= {bcd_adj[BCD_W-2:0], bin, 1'b0};
    end
  end

  // output stage holds one word back so the final one can be flagged
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid    <= 1'b0;
      last_word     <= 1'b0;
      pending_valid <= 1'b0;
    end else begin
      word_valid <= 1'b0;
      if (cmd.zero) begin
        word_valid <= 1'b1;
        word_code  <= WORD_ZERO;
        last_word  <= 1'b1;
      end else if (cmd.flush) begin
        word_valid    <= pending_valid;
        word_code     <= pending;
        last_word     <= 1'b1;
        pending_valid <= 1'b0;
      end else if (cmd.emit && hit) begin
        word_valid    <= pending_valid;
        word_code     <= pending;
        last_word     <= 1'b0;
        pending       <= word;
        pending_valid <= 1'b1;
      end
    end
  end

endmodule

### src/itw_controller.sv
// itw_controller: sequencer for conversion shifts and the walk over groups
// and word slots. Depends on itw_pkg.
`timescale 1ns / 1ps

module itw_controller
  import itw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  itw_stat_t stat,
  output itw_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_CHECK,
    ST_EMIT,
    ST_FLUSH,
    ST_ZERO
  } state_t;

  state_t             state;
  logic [SHIFT_W-1:0] cnt;
  logic [GRP_W-1:0]   grp;
  slot_t              slot;

  // commands decoded from the state
  always_comb begin
    cmd.load  = (state == ST_IDLE) && start;
    cmd.shift = (state == ST_CONV);
    cmd.emit  = (state == ST_EMIT);
    cmd.flush = (state == ST_FLUSH);
    cmd.zero  = (state == ST_ZERO);
    cmd.grp   = grp;
    cmd.slot  = slot;
  end

  // state and registered busy
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      cnt   <= '0;
      grp   <= '0;
      slot  <= SLOT_HDIGIT;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_CONV;
            busy  <= 1'b1;
            cnt   <= '0;
          end
        end
        ST_CONV: begin
          cnt <= cnt + 1'b1;
          if (cnt == SHIFT_W'(NUM_W - 1)) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          grp  <= GRP_W'(GROUPS - 1);
          slot <= SLOT_HDIGIT;
          if (stat.is_zero) begin
            state <= ST_ZERO;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          case (slot)
            SLOT_HDIGIT:  slot <= SLOT_HUNDRED;
            SLOT_HUNDRED: slot <= SLOT_TENS;
            SLOT_TENS:    slot <= SLOT_UNIT;
            SLOT_UNIT:    slot <= SLOT_SCALE;
            default: begin
              slot <= SLOT_HDIGIT;
              if (grp == '0) begin
                state <= ST_FLUSH;
              end else begin
                grp <= grp - 1'b1;
              end
            end
          endcase
        end
        ST_FLUSH: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
        ST_ZERO: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

### src/integer_to_word_tokens_unit.sv
// integer_to_word_tokens_unit: spells a 31-bit number as English word codes.
// Usage:
//   A number is taken at a rising edge with start high and busy low; busy
//   rises the cycle after and stays high while the number is worked on.
//   Each word appears on word_code for exactly one cycle with word_valid
//   high; last_word marks the final word of the number. The receiver
//   cannot stall, so every strobed word must be taken as it comes.
// Sequence:
//   shift-and-add-three BCD conversion of the bits, a check state, then a
//   walk over four digit groups of five word slots each and a flush state,
//   all with busy high; a new number is taken only once busy is low. The
//   words are spread over the walk, delayed by one word in the output
//   register; the last word is strobed in the cycle busy falls. For zero the
//   single word Zero follows the check state instead of the walk. The
//   conversion loop of the datapath takes the bulk of the busy time.
// Reset:
//   synchronous rst returns the sequencer to idle and clears the strobe.
// Depends on itw_pkg, itw_controller and itw_datapath.
`timescale 1ns / 1ps

module integer_to_word_tokens_unit
  import itw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [NUM_W-1:0]  number,
  output logic              word_valid,
  output logic [WORD_W-1:0] word_code,
  output logic              last_word
);

  itw_cmd_t  cmd;
  itw_stat_t stat;

  itw_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  itw_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .number     (number),
    .cmd        (cmd),
    .stat       (stat),
    .word_valid (word_valid),
    .word_code  (word_code),
    .last_word  (last_word)
  );

endmodule
